// ===== design/osm_pkg.sv =====
// Package for the order statistic multiset: request/result types, codes, and enums.
package osm_pkg;

    localparam int KEY_W  = 32;
    localparam int RANK_W = 6;
    localparam int CNT_W  = 7;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_ERASE_VAL = 3'd1;
    localparam logic [OP_W-1:0] OP_ERASE_AT  = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE_RNG = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd5;
    localparam logic [OP_W-1:0] OP_SELECT    = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANK   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [KEY_W-1:0]  key_value;
        logic [RANK_W-1:0] first_rank;
        logic [RANK_W-1:0] last_rank;
    } t_req;

    typedef struct packed {
        logic [KEY_W-1:0]  selected_value;
        logic [CNT_W-1:0]  count_below;
        logic [CNT_W-1:0]  count_at_most;
        logic [CNT_W-1:0]  count_same;
        logic [CNT_W-1:0]  count_at_least;
        logic [CNT_W-1:0]  count_above;
        logic [CNT_W-1:0]  occupancy;
        logic [STAT_W-1:0] status;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT
    } t_state;

    // Command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL
    } t_cell_op;

endpackage

// ===== design/order_statistic_multiset.sv =====
// Top level of the order statistic multiset: cell chain plus request sequencer.
//
// Keeps up to CAPACITY values sorted in a chain of cells, one value per cell.
// A request is taken when i_start is high and o_busy is low; o_busy rises on
// the next cycle. Every request returns one result, shown on o_rsp with o_done
// high for a single cycle once the request has passed through S_EXEC; the
// receiver has no way to stall it. Insert, erase, clear, query and select
// handle a request in steps: first every cell compares the key at once, then
// the ranks are counted and the chain moves. Erasing a range of k ranks goes
// on in S_SHIFT when k > 1, as the chain closes the gap one cell position per cycle;
// its result still comes out of S_EXEC while o_busy stays high for the rest.
// The store needs no clearing after reset: the element count alone marks
// which cells are in use.
module order_statistic_multiset import osm_pkg::*; #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = (CW > RANK_W) ? CW : RANK_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [RANK_W-1:0]      r_left, n_left;
    t_req                   r_req;
    t_rsp                   r_rsp, n_rsp;
    logic                   r_done;

    logic                   cap;
    t_cell_op               cell_cmd;
    logic [CW-1:0]          cell_pos;
    logic [VALUE_WIDTH-1:0] cmp_key;
    logic [VALUE_WIDTH-1:0] ins_key;
    logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]    lt_vec, le_vec, hit_vec;
    logic [CAPACITY:0]      lt_ext, le_ext;

    logic [CW-1:0]          lt_cnt, le_cnt;
    logic                   found;
    logic [VALUE_WIDTH-1:0] sel_val;
    logic                   ra_ok, rb_ok;
    logic [CNT_W-1:0]       rng_len;

    assign cap     = i_start && (r_state == S_IDLE);
    assign cmp_key = VALUE_WIDTH'(i_req.key_value);
    assign ins_key = VALUE_WIDTH'(r_req.key_value);

    // Chain of cells, each linked to its neighbors; the end cells take the insert key in place of a missing neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left_val;
        logic [VALUE_WIDTH-1:0] right_val;

        if (g == 0) begin : g_first
            assign left_val = ins_key;
        end else begin : g_inner_l
            assign left_val = cell_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_val = ins_key;
        end else begin : g_inner_r
            assign right_val = cell_val[g+1];
        end

        osm_cell #(
            .IDX         (g),
            .VALUE_WIDTH (VALUE_WIDTH),
            .CW          (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cap      (cap),
            .i_cmp_key  (cmp_key),
            .i_sel_rank (i_req.first_rank),
            .i_count    (r_count),
            .i_cmd      (cell_cmd),
            .i_pos      (cell_pos),
            .i_ins_key  (ins_key),
            .i_left     (left_val),
            .i_right    (right_val),
            .o_value    (cell_val[g]),
            .o_lt       (lt_vec[g]),
            .o_le       (le_vec[g]),
            .o_hit      (hit_vec[g])
        );
    end

    assign lt_ext = {1'b0, lt_vec};
    assign le_ext = {1'b0, le_vec};

    // Turn the thermometer flags into rank counts; pick the selected value
    always_comb begin
        lt_cnt  = '0;
        le_cnt  = '0;
        found   = 1'b0;
        sel_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (lt_ext[i] && !lt_ext[i+1]) begin
                lt_cnt = lt_cnt | CW'(i + 1);
            end
            if (le_ext[i] && !le_ext[i+1]) begin
                le_cnt = le_cnt | CW'(i + 1);
            end
            found = found | (le_vec[i] & ~lt_vec[i]);
            if (hit_vec[i]) begin
                sel_val = sel_val | cell_val[i];
            end
        end
    end

    assign ra_ok   = RW'(r_req.first_rank) < RW'(r_count);
    assign rb_ok   = RW'(r_req.last_rank) < RW'(r_count);
    assign rng_len = CNT_W'(r_req.last_rank) - CNT_W'(r_req.first_rank) + CNT_W'(1);

    // Sequencer: next state, count update, cell command and result
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        n_rsp    = r_rsp;
        cell_cmd = CELL_HOLD;
        cell_pos = CW'(r_req.first_rank);
        unique case (r_state)
            S_IDLE: begin
                if (cap) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_rsp   = '0;
                unique case (r_req.operation)
                    OP_INSERT: begin
                        if (r_count == CAP_CNT) begin
                            n_rsp.status = ST_FULL;
                        end else begin
                            cell_cmd = CELL_INS;
                            cell_pos = le_cnt;
                            n_count  = r_count + CW'(1);
                        end
                    end
                    OP_ERASE_VAL: begin
                        if (found) begin
                            cell_cmd = CELL_DEL;
                            cell_pos = lt_cnt;
                            n_count  = r_count - CW'(1);
                        end else begin
                            n_rsp.status = ST_ABSENT;
                        end
                    end
                    OP_ERASE_AT: begin
                        if (ra_ok) begin
                            cell_cmd = CELL_DEL;
                            n_count  = r_count - CW'(1);
                        end else begin
                            n_rsp.status = ST_RANK;
                        end
                    end
                    OP_ERASE_RNG: begin
                        if (ra_ok && rb_ok && (r_req.last_rank >= r_req.first_rank)) begin
                            cell_cmd = CELL_DEL;
                            n_count  = r_count - CW'(rng_len);
                            n_left   = r_req.last_rank - r_req.first_rank;
                            if (n_left != '0) begin
                                n_state = S_SHIFT;
                            end
                        end else begin
                            n_rsp.status = ST_RANK;
                        end
                    end
                    OP_CLEAR: begin
                        n_count = '0;
                    end
                    OP_QUERY: begin
                        n_rsp.count_below    = CNT_W'(lt_cnt);
                        n_rsp.count_at_most  = CNT_W'(le_cnt);
                        n_rsp.count_same     = CNT_W'(le_cnt - lt_cnt);
                        n_rsp.count_at_least = CNT_W'(r_count - lt_cnt);
                        n_rsp.count_above    = CNT_W'(r_count - le_cnt);
                    end
                    OP_SELECT: begin
                        if (ra_ok) begin
                            n_rsp.selected_value = KEY_W'(sel_val);
                        end else begin
                            n_rsp.status = ST_RANK;
                        end
                    end
                    default: ;
                endcase
                n_rsp.occupancy = CNT_W'(n_count);
            end
            S_SHIFT: begin
                cell_cmd = CELL_DEL;
                n_left   = r_left - RANK_W'(1);
                if (r_left == RANK_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= (r_state == S_EXEC);
        end
    end

    // Request, result and shift-counter registers
    always_ff @(posedge i_clk) begin
        if (cap) begin
            r_req <= i_req;
        end
        if (r_state == S_EXEC) begin
            r_rsp <= n_rsp;
        end
        r_left <= n_left;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== design/osm_cell.sv =====
// One storage cell of the sorted chain: holds a value, compares it, shifts with neighbors.
module osm_cell import osm_pkg::*; #(
    parameter int IDX         = 0,
    parameter int VALUE_WIDTH = 32,
    parameter int CW          = 7
) (
    input  logic                   i_clk,
    input  logic                   i_cap,
    input  logic [VALUE_WIDTH-1:0] i_cmp_key,
    input  logic [RANK_W-1:0]      i_sel_rank,
    input  logic [CW-1:0]          i_count,
    input  t_cell_op               i_cmd,
    input  logic [CW-1:0]          i_pos,
    input  logic [VALUE_WIDTH-1:0] i_ins_key,
    input  logic [VALUE_WIDTH-1:0] i_left,
    input  logic [VALUE_WIDTH-1:0] i_right,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic                   o_lt,
    output logic                   o_le,
    output logic                   o_hit
);

    localparam int RW = (CW > RANK_W) ? CW : RANK_W;
    localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
    localparam logic [RW-1:0] MY_IDX_R = RW'(IDX);

    logic [VALUE_WIDTH-1:0] r_value;
    logic                   r_lt;
    logic                   r_le;
    logic                   r_hit;
    logic                   occupied;

    assign occupied = (MY_IDX < i_count);

    // Capture compare flags when a request is taken
    always_ff @(posedge i_clk) begin
        if (i_cap) begin
            r_lt  <= occupied && (r_value < i_cmp_key);
            r_le  <= occupied && (r_value <= i_cmp_key);
            r_hit <= (MY_IDX_R == RW'(i_sel_rank));
        end
    end

    // Hold, open a slot for the key, or close a gap from the right
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CELL_HOLD: ;
            CELL_INS: begin
                if (MY_IDX == i_pos) begin
                    r_value <= i_ins_key;
                end else if (MY_IDX > i_pos) begin
                    r_value <= i_left;
                end
            end
            CELL_DEL: begin
                if (MY_IDX >= i_pos) begin
                    r_value <= i_right;
                end
            end
            default: ;
        endcase
    end

    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_le    = r_le;
    assign o_hit   = r_hit;

endmodule

// ===== design/osm_checker.sv =====
// Port-level checker for the order statistic multiset, bound to the top level.
module osm_checker import osm_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_done,
    input t_rsp o_rsp
);

    // Taken request blocks the next one
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy did not rise after a request");

    // Every taken request is answered by a result strobe
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##2 o_done)
        else $error("result strobe missing after a request");

    // Occupancy never exceeds the store size
    a_occupancy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.occupancy <= CNT_W'(CAPACITY)))
        else $error("occupancy above capacity");

    // Failed requests carry no counts
    a_fail_no_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status != ST_OK)) |->
            (o_rsp.count_below == '0) && (o_rsp.count_same == '0)
            && (o_rsp.selected_value == '0))
        else $error("counts reported on a failed request");

    // Rank counts stay consistent
    a_count_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.count_at_most == CNT_W'(o_rsp.count_below + o_rsp.count_same)))
        else $error("at-most count differs from below plus same");

endmodule

bind order_statistic_multiset osm_checker #(
    .CAPACITY (CAPACITY)
) u_osm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
